@@ rtl/tal_pkg.sv @@
// Shared constants and codes of the TCP ack latency matcher.
package tal_pkg;

    localparam int DEF_NUM_FLOWS  = 16;
    localparam int DEF_SEGS_PER_DIR = 16;
    localparam int MAX_RESULTS    = 16;
    localparam logic [7:0] DEF_THRESHOLD = 8'd3;

    // error codes reported with every result item
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_FLOW_FULL = 2'd1,
        ERR_SEG_FULL  = 2'd2
    } t_err;

endpackage

@@ rtl/tal_ram.sv @@
// Simple dual-port synchronous RAM with registered read.
module tal_ram #(
    parameter int AW    = 4,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    localparam int DEPTH = 1 << AW;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/tcp_ack_latency_matcher.sv @@
// Top level of the TCP ack latency matcher: sequencer around three RAMs.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------
//  input    | i_start, o_busy              | i_src_ip .. i_packet_number
//  result   | o_valid (one-cycle strobe)   | o_match_valid .. o_last_result
//  config   | i_cfg_valid, o_cfg_ready     | i_cfg_data (alert threshold)
//
// Each item runs from accept to the next accept through a scan of the F flows
// in use, a scan of the S = SEGS_PER_DIRECTION sending slots and P release passes
// (at most MAX_RESULTS) over the receiving slots; a scan skips a free slot but reads
// and compares a used one, as the flow and segment RAMs have a single read port.
// Reset is synchronous, active low; no clearing pass is needed (flows fill in
// order, segment valid masks live in the direction RAM, zeroed on allocation).
// The threshold is taken only while idle; the receiver cannot stall and each
// result is shown for exactly one cycle.
module tcp_ack_latency_matcher #(
    parameter int NUM_FLOWS          = tal_pkg::DEF_NUM_FLOWS,
    parameter int SEGS_PER_DIRECTION = tal_pkg::DEF_SEGS_PER_DIR
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_src_ip,
    input  logic [15:0] i_src_port,
    input  logic [31:0] i_dst_ip,
    input  logic [15:0] i_dst_port,
    input  logic [31:0] i_seq_number,
    input  logic [31:0] i_ack_number,
    input  logic [15:0] i_payload_length,
    input  logic        i_syn_flag,
    input  logic        i_fin_flag,
    input  logic        i_ack_flag,
    input  logic [47:0] i_timestamp,
    input  logic [31:0] i_packet_number,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    output logic        o_match_valid,
    output logic [31:0] o_sent_packet_number,
    output logic [31:0] o_sent_seq_number,
    output logic [31:0] o_acked_by,
    output logic [47:0] o_send_time,
    output logic [47:0] o_latency,
    output logic        o_was_retransmission,
    output logic        o_dup_ack_alert,
    output logic [7:0]  o_dup_ack_count,
    output logic [1:0]  o_error_code,
    output logic        o_last_result
);
    localparam int S     = SEGS_PER_DIRECTION;
    localparam int FW    = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
    localparam int CW    = $clog2(NUM_FLOWS + 1);
    localparam int DW    = FW + 1;
    localparam int SW    = (S > 1) ? $clog2(S) : 1;
    localparam int DIR_W = 40 + S;
    localparam int SEG_W = 144;
    localparam int RCW   = $clog2(tal_pkg::MAX_RESULTS + 1);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_FL_RD  = 15'b000000000000010,
        S_FL_CMP = 15'b000000000000100,
        S_DIR_S  = 15'b000000000001000,
        S_DIR_R  = 15'b000000000010000,
        S_DIR_C  = 15'b000000000100000,
        S_DS_RD  = 15'b000000001000000,
        S_DS_CMP = 15'b000000010000000,
        S_DS_END = 15'b000000100000000,
        S_ACK    = 15'b000001000000000,
        S_RL_RD  = 15'b000010000000000,
        S_RL_CMP = 15'b000100000000000,
        S_RL_END = 15'b001000000000000,
        S_WB     = 15'b010000000000000,
        S_FIN    = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    // latched item
    logic [47:0] r_lo, r_hi;
    logic        r_fwd;
    logic [31:0] r_seq, r_ack, r_pkt;
    logic [15:0] r_len;
    logic        r_syn, r_fin, r_ackf;
    logic [47:0] r_ts;
    logic [7:0]  r_thr;

    // flow and direction context
    logic [CW-1:0] r_fill, r_fidx;
    logic [FW-1:0] r_flow;
    logic          r_new;
    logic [31:0]   r_s_ack, r_r_ack;
    logic [7:0]    r_s_dup, r_r_dup;
    logic [S-1:0]  r_s_mask, r_r_mask;
    logic          r_wb2;

    // segment scans
    logic [SW:0]   r_slot;
    logic          r_retr;
    tal_pkg::t_err r_err;
    logic [RCW-1:0] r_rel;
    logic          r_bfound;
    logic [SW-1:0] r_bslot;
    logic [31:0]   r_bseq, r_bpkt;
    logic [47:0]   r_bsent;

    // result waiting to learn whether it is the last one
    logic          r_pend;
    logic [31:0]   r_p_pkt, r_p_seq;
    logic [47:0]   r_p_sent, r_p_lat;

    // output registers
    logic          r_o_valid, r_o_match, r_o_retr, r_o_alert, r_o_last;
    logic [31:0]   r_o_pkt, r_o_seq, r_o_ack;
    logic [47:0]   r_o_sent, r_o_lat;
    logic [7:0]    r_o_dup;
    logic [1:0]    r_o_err;

    // RAM ports
    logic              fl_we;
    logic [FW-1:0]     fl_raddr;
    logic [95:0]       fl_rdata;
    logic              dr_we;
    logic [DW-1:0]     dr_waddr, dr_raddr;
    logic [DIR_W-1:0]  dr_wdata, dr_rdata;
    logic              sg_we;
    logic [DW+SW-1:0]  sg_waddr, sg_raddr;
    logic [SEG_W-1:0]  sg_wdata, sg_rdata;

    logic [DW-1:0] sdir, rdir;
    logic [SW-1:0] free_slot;
    logic          free_ok;
    logic [31:0]   exp_ack;
    logic [31:0]   sg_seq, sg_exp, sg_pkt;
    logic [47:0]   sg_sent;
    logic          alert;
    logic [47:0]   src_ep, dst_ep;

    assign sdir    = {r_flow, ~r_fwd};
    assign rdir    = {r_flow, r_fwd};
    assign exp_ack = r_seq + 32'(r_len) + 32'(r_syn) + 32'(r_fin);
    assign {sg_seq, sg_exp, sg_pkt, sg_sent} = sg_rdata;
    assign alert   = (r_r_dup >= r_thr);
    assign src_ep  = {i_src_ip, i_src_port};
    assign dst_ep  = {i_dst_ip, i_dst_port};

    // lowest free slot of the sending direction
    always_comb begin
        free_slot = '0;
        free_ok   = 1'b0;
        for (int i = S - 1; i >= 0; i--) begin
            if (!r_s_mask[i]) begin
                free_slot = SW'(i);
                free_ok   = 1'b1;
            end
        end
    end

    // RAM addressing
    always_comb begin
        fl_we    = (r_state == S_FL_RD) && (r_fidx == r_fill) &&
                   (r_fill != CW'(NUM_FLOWS));
        fl_raddr = r_fidx[FW-1:0];
        dr_raddr = (r_state == S_DIR_S) ? sdir : rdir;
        dr_we    = (r_state == S_WB);
        dr_waddr = r_wb2 ? rdir : sdir;
        dr_wdata = r_wb2 ? {r_r_ack, r_r_dup, r_r_mask} : {r_s_ack, r_s_dup, r_s_mask};
        sg_raddr = (r_state == S_RL_RD) ? {rdir, r_slot[SW-1:0]} : {sdir, r_slot[SW-1:0]};
        sg_we    = (r_state == S_DS_END) && !r_retr && free_ok;
        sg_waddr = {sdir, free_slot};
        sg_wdata = {r_seq, exp_ack, r_pkt, r_ts};
    end

    tal_ram #(.AW(FW), .WIDTH(96)) u_flow_ram (
        .i_clk(i_clk), .i_we(fl_we), .i_waddr(r_fill[FW-1:0]),
        .i_wdata({r_lo, r_hi}), .i_raddr(fl_raddr), .o_rdata(fl_rdata)
    );

    tal_ram #(.AW(DW), .WIDTH(DIR_W)) u_dir_ram (
        .i_clk(i_clk), .i_we(dr_we), .i_waddr(dr_waddr),
        .i_wdata(dr_wdata), .i_raddr(dr_raddr), .o_rdata(dr_rdata)
    );

    tal_ram #(.AW(DW + SW), .WIDTH(SEG_W)) u_seg_ram (
        .i_clk(i_clk), .i_we(sg_we), .i_waddr(sg_waddr),
        .i_wdata(sg_wdata), .i_raddr(sg_raddr), .o_rdata(sg_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_start) n_state = S_FL_RD;
            S_FL_RD: begin
                if (r_fidx == r_fill) begin
                    n_state = (r_fill == CW'(NUM_FLOWS)) ? S_IDLE : S_DIR_S;
                end else begin
                    n_state = S_FL_CMP;
                end
            end
            S_FL_CMP: n_state = (fl_rdata == {r_lo, r_hi}) ? S_DIR_S : S_FL_RD;
            S_DIR_S:  n_state = S_DIR_R;
            S_DIR_R:  n_state = S_DIR_C;
            S_DIR_C:  n_state = (r_len != 16'd0) ? S_DS_RD : S_ACK;
            S_DS_RD: begin
                if (r_slot == (SW+1)'(S)) n_state = S_DS_END;
                else if (r_s_mask[r_slot[SW-1:0]]) n_state = S_DS_CMP;
            end
            S_DS_CMP: n_state = S_DS_RD;
            S_DS_END: n_state = S_ACK;
            S_ACK:    n_state = r_ackf ? S_RL_RD : S_WB;
            S_RL_RD: begin
                if (r_slot == (SW+1)'(S)) n_state = S_RL_END;
                else if (r_r_mask[r_slot[SW-1:0]]) n_state = S_RL_CMP;
            end
            S_RL_CMP: n_state = S_RL_RD;
            S_RL_END: begin
                if (!r_bfound || (r_rel == RCW'(tal_pkg::MAX_RESULTS - 1))) n_state = S_WB;
                else n_state = S_RL_RD;
            end
            S_WB:     if (r_wb2) n_state = S_FIN;
            S_FIN:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= tal_pkg::DEF_THRESHOLD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // flow fill count (flows are never freed, so they fill in order)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (fl_we) begin
            r_fill <= r_fill + CW'(1);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_lo   <= (src_ep < dst_ep) ? src_ep : dst_ep;
                r_hi   <= (src_ep < dst_ep) ? dst_ep : src_ep;
                r_fwd  <= (src_ep <= dst_ep);
                r_seq  <= i_seq_number;
                r_ack  <= i_ack_number;
                r_pkt  <= i_packet_number;
                r_len  <= i_payload_length;
                r_syn  <= i_syn_flag;
                r_fin  <= i_fin_flag;
                r_ackf <= i_ack_flag;
                r_ts   <= i_timestamp;
                r_fidx <= '0;
                r_retr <= 1'b0;
                r_err  <= tal_pkg::ERR_NONE;
                r_rel  <= '0;
                r_pend <= 1'b0;
                r_wb2  <= 1'b0;
            end
            S_FL_RD: begin
                if (r_fidx == r_fill) begin
                    r_flow <= r_fill[FW-1:0];
                    r_new  <= 1'b1;
                end
            end
            S_FL_CMP: begin
                r_flow <= r_fidx[FW-1:0];
                r_new  <= 1'b0;
                r_fidx <= r_fidx + CW'(1);
            end
            S_DIR_R: begin
                {r_s_ack, r_s_dup, r_s_mask} <= r_new ? '0 : dr_rdata;
            end
            S_DIR_C: begin
                {r_r_ack, r_r_dup, r_r_mask} <= r_new ? '0 : dr_rdata;
                r_slot <= '0;
            end
            S_DS_RD: begin
                if ((r_slot != (SW+1)'(S)) && !r_s_mask[r_slot[SW-1:0]]) begin
                    r_slot <= r_slot + (SW+1)'(1);
                end
            end
            S_DS_CMP: begin
                if (sg_seq == r_seq) r_retr <= 1'b1;
                r_slot <= r_slot + (SW+1)'(1);
            end
            S_DS_END: begin
                if (!r_retr) begin
                    if (free_ok) r_s_mask[free_slot] <= 1'b1;
                    else r_err <= tal_pkg::ERR_SEG_FULL;
                end
            end
            S_ACK: begin
                if (r_ackf) begin
                    if (r_ack == r_r_ack) begin
                        if (r_r_dup != 8'hFF) r_r_dup <= r_r_dup + 8'd1;
                    end else begin
                        r_r_ack <= r_ack;
                        r_r_dup <= 8'd1;
                    end
                end
                r_slot   <= '0;
                r_bfound <= 1'b0;
            end
            S_RL_RD: begin
                if ((r_slot != (SW+1)'(S)) && !r_r_mask[r_slot[SW-1:0]]) begin
                    r_slot <= r_slot + (SW+1)'(1);
                end
            end
            S_RL_CMP: begin
                if ((sg_exp <= r_ack) && (!r_bfound || (sg_seq < r_bseq))) begin
                    r_bfound <= 1'b1;
                    r_bslot  <= r_slot[SW-1:0];
                    r_bseq   <= sg_seq;
                    r_bpkt   <= sg_pkt;
                    r_bsent  <= sg_sent;
                end
                r_slot <= r_slot + (SW+1)'(1);
            end
            S_RL_END: begin
                if (r_bfound) begin
                    r_r_mask[r_bslot] <= 1'b0;
                    r_rel <= r_rel + RCW'(1);
                    if (r_ts >= r_bsent) begin
                        r_pend   <= 1'b1;
                        r_p_pkt  <= r_bpkt;
                        r_p_seq  <= r_bseq;
                        r_p_sent <= r_bsent;
                        r_p_lat  <= r_ts - r_bsent;
                    end
                end
                r_slot   <= '0;
                r_bfound <= 1'b0;
            end
            S_WB: begin
                r_wb2 <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result emission
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            if ((r_state == S_FL_RD) && (r_fidx == r_fill) &&
                (r_fill == CW'(NUM_FLOWS))) begin
                // flow table full: bare error item
                r_o_valid <= 1'b1;
                r_o_match <= 1'b0;
                r_o_pkt   <= '0;
                r_o_seq   <= '0;
                r_o_ack   <= '0;
                r_o_sent  <= '0;
                r_o_lat   <= '0;
                r_o_retr  <= 1'b0;
                r_o_alert <= 1'b0;
                r_o_dup   <= '0;
                r_o_err   <= tal_pkg::ERR_FLOW_FULL;
                r_o_last  <= 1'b1;
            end else if (((r_state == S_RL_END) && r_bfound && (r_ts >= r_bsent) && r_pend)
                         || (r_state == S_FIN)) begin
                // flush the held item; last one only from the final state
                r_o_valid <= 1'b1;
                r_o_match <= r_pend;
                r_o_pkt   <= r_pend ? r_p_pkt : '0;
                r_o_seq   <= r_pend ? r_p_seq : '0;
                r_o_ack   <= r_pend ? r_ack : '0;
                r_o_sent  <= r_pend ? r_p_sent : '0;
                r_o_lat   <= r_pend ? r_p_lat : '0;
                r_o_retr  <= r_retr;
                r_o_alert <= alert;
                r_o_dup   <= r_r_dup;
                r_o_err   <= r_err;
                r_o_last  <= (r_state == S_FIN);
            end
        end
    end

    assign o_busy               = (r_state != S_IDLE);
    assign o_cfg_ready          = (r_state == S_IDLE);
    assign o_valid              = r_o_valid;
    assign o_match_valid        = r_o_match;
    assign o_sent_packet_number = r_o_pkt;
    assign o_sent_seq_number    = r_o_seq;
    assign o_acked_by           = r_o_ack;
    assign o_send_time          = r_o_sent;
    assign o_latency            = r_o_lat;
    assign o_was_retransmission = r_o_retr;
    assign o_dup_ack_alert      = r_o_alert;
    assign o_dup_ack_count      = r_o_dup;
    assign o_error_code         = r_o_err;
    assign o_last_result        = r_o_last;

`ifndef SYNTHESIS
    a_last_then_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |=> !r_o_valid)
        else $error("result right after a last result");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(NUM_FLOWS))
        else $error("flow fill count out of range");
    a_flow_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_err == tal_pkg::ERR_FLOW_FULL)) |-> (r_o_last && !r_o_match))
        else $error("flow full error not a lone status item");
    a_rel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_IDLE) |-> (r_rel <= RCW'(tal_pkg::MAX_RESULTS)))
        else $error("too many releases");
    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_last) |-> $past(r_state == S_RL_END))
        else $error("non-final result outside release");
`endif
endmodule
